@@ hw/rtl/mbsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbsp_pkg
// shared types, byte codes and helpers of the midi byte stream parser
// ----------------------------------------------------------------------------
package mbsp_pkg;

  localparam logic [7:0] RT_FIRST      = 8'hF8;
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] RT_START      = 8'hFA;
  localparam logic [7:0] RT_CONTINUE   = 8'hFB;
  localparam logic [7:0] RT_STOP       = 8'hFC;
  localparam logic [7:0] SYS_FIRST     = 8'hF0;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] NO_STATUS     = 8'h00;

  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_POLY_AT    = 4'hA;
  localparam logic [3:0] HI_CC         = 4'hB;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_CHAN_AT    = 4'hD;
  localparam logic [3:0] HI_BEND       = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  typedef enum logic [3:0] {
    EV_NOTE_OFF = 4'd0,
    EV_NOTE_ON  = 4'd1,
    EV_POLY_AT  = 4'd2,
    EV_CC       = 4'd3,
    EV_PROGRAM  = 4'd4,
    EV_CHAN_AT  = 4'd5,
    EV_BEND     = 4'd6,
    EV_CLOCK    = 4'd7,
    EV_START    = 4'd8,
    EV_CONTINUE = 4'd9,
    EV_STOP     = 4'd10,
    EV_SONG_POS = 4'd11
  } event_kind_t;

  // data bytes a status byte takes
  function automatic logic [1:0] bytes_needed(input logic [7:0] st);
    logic [1:0] n;
    n = 2'd0;
    if (st[7:4] == HI_PROGRAM || st[7:4] == HI_CHAN_AT) begin
      n = 2'd1;
    end else if (st[7] && st[7:4] != HI_SYSTEM) begin
      n = 2'd2;
    end else if (st == SYS_SONG_POS) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/midi_byte_stream_parser_unit.sv @@
// an accepted byte is held in the input register, then its result is written to the result register
// throughput: one byte per cycle while the result side keeps taking items
// realtime clock, start, continue and stop bytes give a result at once, data bytes only when a message completes
// reset: synchronous active-low rst_n clears running and pending status, data count,
// stored data bytes and both valid flags
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// running-status midi parser: one raw byte in, at most one decoded event out
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  input  logic [1:0] in_source_tag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_event_kind,
  output logic [1:0] out_event_source,
  output logic [3:0] out_channel_number,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data,
  output logic [13:0] out_combined_value
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [1:0] s1_src_r;

  // parser state
  logic [7:0] running_r, running_nxt;
  logic [7:0] pending_r, pending_nxt;
  logic [1:0] held_r, held_nxt;
  logic [6:0] store_r [2];
  logic [6:0] store_nxt [2];

  // result register
  logic        out_valid_r;
  mbsp_pkg::event_kind_t kind_r, kind_nxt;
  logic [1:0]  src_r;
  logic [3:0]  chan_r, chan_nxt;
  logic [6:0]  d1_r, d1_nxt;
  logic [6:0]  d2_r, d2_nxt;
  logic [13:0] comb_r, comb_nxt;
  logic        res_nxt;

  logic       advance;
  logic [7:0] pend;
  logic [1:0] hold;
  logic [1:0] need;
  logic       have_status;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    running_nxt  = running_r;
    pending_nxt  = pending_r;
    held_nxt     = held_r;
    store_nxt[0] = store_r[0];
    store_nxt[1] = store_r[1];
    res_nxt      = 1'b0;
    kind_nxt     = mbsp_pkg::EV_NOTE_OFF;
    chan_nxt     = 4'd0;
    d1_nxt       = 7'd0;
    d2_nxt       = 7'd0;
    comb_nxt     = 14'd0;
    pend         = pending_r;
    hold         = held_r;
    need         = 2'd0;
    have_status  = 1'b1;

    if (s1_byte_r >= mbsp_pkg::RT_FIRST) begin
      res_nxt = 1'b1;
      case (s1_byte_r)
        mbsp_pkg::RT_CLOCK:    kind_nxt = mbsp_pkg::EV_CLOCK;
        mbsp_pkg::RT_START:    kind_nxt = mbsp_pkg::EV_START;
        mbsp_pkg::RT_CONTINUE: kind_nxt = mbsp_pkg::EV_CONTINUE;
        mbsp_pkg::RT_STOP:     kind_nxt = mbsp_pkg::EV_STOP;
        default:               res_nxt  = 1'b0;
      endcase
    end else if (s1_byte_r[7]) begin
      if (s1_byte_r >= mbsp_pkg::SYS_FIRST) begin
        pending_nxt = (s1_byte_r == mbsp_pkg::SYS_SONG_POS) ? s1_byte_r
                                                            : mbsp_pkg::NO_STATUS;
      end else begin
        running_nxt = s1_byte_r;
        pending_nxt = s1_byte_r;
      end
      held_nxt = 2'd0;
    end else begin
      if (pend == mbsp_pkg::NO_STATUS) begin
        if (running_r == mbsp_pkg::NO_STATUS) begin
          have_status = 1'b0;
        end else begin
          pend = running_r;
          hold = 2'd0;
        end
      end
      if (have_status) begin
        need = mbsp_pkg::bytes_needed(pend);
        if (need != 2'd0) begin
          if (hold < 2'd2) begin
            store_nxt[hold[0]] = s1_byte_r[6:0];
            hold = hold + 2'd1;
          end
        end
        pending_nxt = pend;
        held_nxt    = hold;
        if (need != 2'd0 && hold >= need) begin
          held_nxt    = 2'd0;
          pending_nxt = (pend >= mbsp_pkg::SYS_FIRST) ? mbsp_pkg::NO_STATUS : running_r;
          d1_nxt      = store_nxt[0];
          d2_nxt      = store_nxt[1];
          res_nxt     = 1'b1;
          case (pend[7:4])
            mbsp_pkg::HI_NOTE_OFF: kind_nxt = mbsp_pkg::EV_NOTE_OFF;
            mbsp_pkg::HI_NOTE_ON:  kind_nxt = (store_nxt[1] == 7'd0) ? mbsp_pkg::EV_NOTE_OFF
                                                                     : mbsp_pkg::EV_NOTE_ON;
            mbsp_pkg::HI_POLY_AT:  kind_nxt = mbsp_pkg::EV_POLY_AT;
            mbsp_pkg::HI_CC:       kind_nxt = mbsp_pkg::EV_CC;
            mbsp_pkg::HI_PROGRAM:  kind_nxt = mbsp_pkg::EV_PROGRAM;
            mbsp_pkg::HI_CHAN_AT:  kind_nxt = mbsp_pkg::EV_CHAN_AT;
            mbsp_pkg::HI_BEND:     kind_nxt = mbsp_pkg::EV_BEND;
            default: begin
              if (pend == mbsp_pkg::SYS_SONG_POS) begin
                kind_nxt = mbsp_pkg::EV_SONG_POS;
              end else begin
                res_nxt = 1'b0;
              end
            end
          endcase
          if (pend[7:4] != mbsp_pkg::HI_SYSTEM) begin
            chan_nxt = pend[3:0];
          end
          if (kind_nxt == mbsp_pkg::EV_BEND || kind_nxt == mbsp_pkg::EV_SONG_POS) begin
            comb_nxt = {store_nxt[1], store_nxt[0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= mbsp_pkg::NO_STATUS;
      pending_r   <= mbsp_pkg::NO_STATUS;
      held_r      <= 2'd0;
      store_r[0]  <= 7'd0;
      store_r[1]  <= 7'd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        running_r   <= running_nxt;
        pending_r   <= pending_nxt;
        held_r      <= held_nxt;
        store_r[0]  <= store_nxt[0];
        store_r[1]  <= store_nxt[1];
        out_valid_r <= res_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_midi_byte;
      s1_src_r  <= in_source_tag;
    end
    if (advance) begin
      kind_r <= kind_nxt;
      src_r  <= s1_src_r;
      chan_r <= chan_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      comb_r <= comb_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = kind_r;
  assign out_event_source   = src_r;
  assign out_channel_number = chan_r;
  assign out_first_data     = d1_r;
  assign out_second_data    = d2_r;
  assign out_combined_value = comb_r;

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 2'd1)
    else $error("data count out of range");

  a_running_voice: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == mbsp_pkg::NO_STATUS ||
    (running_r[7] && running_r[7:4] != mbsp_pkg::HI_SYSTEM))
    else $error("running status not a voice status");

  a_pending_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != mbsp_pkg::NO_STATUS && pending_r != mbsp_pkg::SYS_SONG_POS)
    |-> pending_r == running_r)
    else $error("pending voice status differs from running status");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> $stable(pending_r) && $stable(held_r))
    else $error("parser state moved while result stalled");
`endif

endmodule
